>>> rtl/slpc_pkg.sv
// Shared package for the status LED pattern controller.
// Holds operation codes, register indexes, reset values and the state structs.
// No dependencies.
package slpc_pkg;

	// operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_LINK_ACT = 3'd1;
	localparam logic [2:0] OP_REPORT   = 3'd2;
	localparam logic [2:0] OP_NET_ACT  = 3'd3;
	localparam logic [2:0] OP_BRIDGE   = 3'd4;
	localparam logic [2:0] OP_ERROR    = 3'd5;
	localparam logic [2:0] OP_TEST     = 3'd6;

	// configuration register indexes
	localparam logic [1:0] REG_ACTIVITY_LEN = 2'd0;
	localparam logic [1:0] REG_REPORT_LEN   = 2'd1;
	localparam logic [1:0] REG_ALERT_LEN    = 2'd2;
	localparam logic [1:0] REG_TEST_LEN     = 2'd3;

	localparam logic [7:0] ACTIVITY_LEN_RST = 8'd4;
	localparam logic [7:0] REPORT_LEN_RST   = 8'd2;
	localparam logic [7:0] ALERT_LEN_RST    = 8'd12;
	localparam logic [7:0] TEST_LEN_RST     = 8'd24;

	// the twelve-tick phase wraps after this value; double pulse lights at 0 and at DOUBLE_SECOND
	localparam logic [3:0] PHASE12_LAST   = 4'd11;
	localparam logic [3:0] DOUBLE_SECOND  = 4'd2;

	typedef struct packed {
		logic link_connected;
		logic link_advertising;
		logic link_requested;
		logic link_ready;
		logic net_scanning;
		logic net_has_address;
		logic net_associated;
		logic net_requested;
	} status_t;

	typedef struct packed {
		logic link;
		logic net;
		logic activity;
		logic alert;
	} led_t;

	typedef struct packed {
		logic [2:0] phase_eight;
		logic [3:0] phase_twelve;
		logic [7:0] link_left;
		logic [7:0] report_left;
		logic [7:0] net_left;
		logic [7:0] bridge_left;
		logic [7:0] alert_left;
		logic [7:0] test_left;
		logic [3:0] blink_mask;
	} ctl_state_t;

endpackage

>>> rtl/slpc_tick_logic.sv
// Tick evaluation: pattern selection, pulse overrides and counter/phase advance.
// Depends on slpc_pkg.
module slpc_tick_logic (
	input  slpc_pkg::ctl_state_t cur,
	input  slpc_pkg::status_t    status,
	output slpc_pkg::led_t       leds,
	output slpc_pkg::ctl_state_t nxt
);

	logic fast, mid_blink, slow, heart, dbl;
	logic link_hit, report_hit, net_hit, bridge_hit, alert_hit, test_hit;

	assign fast      = cur.phase_eight[0];
	assign mid_blink = cur.phase_eight[1];
	assign slow      = cur.phase_eight[2];
	assign heart     = (cur.phase_eight == 3'd0);
	assign dbl       = (cur.phase_twelve == 4'd0) || (cur.phase_twelve == slpc_pkg::DOUBLE_SECOND);

	assign link_hit   = (cur.link_left   != 8'd0);
	assign report_hit = (cur.report_left != 8'd0);
	assign net_hit    = (cur.net_left    != 8'd0);
	assign bridge_hit = (cur.bridge_left != 8'd0);
	assign alert_hit  = (cur.alert_left  != 8'd0);
	assign test_hit   = (cur.test_left   != 8'd0);

	always_comb begin
		leds = '0;
		// base patterns by priority
		if (status.link_connected) begin
			leds.link = 1'b1;
		end else if (status.link_advertising) begin
			leds.link = mid_blink;
		end else if (status.link_requested && status.link_ready) begin
			leds.link = heart;
		end else if (status.link_requested) begin
			leds.link = slow;
		end

		if (status.net_scanning) begin
			leds.net = fast;
		end else if (status.net_has_address) begin
			leds.net = 1'b1;
		end else if (status.net_associated) begin
			leds.net = dbl;
		end else if (status.net_requested) begin
			leds.net = slow;
		end

		// overrides, later ones win
		if (link_hit) begin
			leds.link     = 1'b1;
			leds.activity = 1'b1;
		end
		if (report_hit) begin
			leds.link     = !status.link_connected;
			leds.activity = 1'b1;
		end
		if (net_hit) begin
			leds.net      = 1'b1;
			leds.activity = 1'b1;
		end
		if (bridge_hit) begin
			leds.activity = 1'b1;
		end
		if (alert_hit) begin
			leds.alert = fast;
		end
		if (test_hit) begin
			if (cur.blink_mask[0]) leds.link     = fast;
			if (cur.blink_mask[1]) leds.net      = fast;
			if (cur.blink_mask[2]) leds.activity = fast;
			if (cur.blink_mask[3]) leds.alert    = fast;
		end
	end

	always_comb begin
		nxt = cur;
		nxt.phase_eight  = cur.phase_eight + 3'd1;
		nxt.phase_twelve = (cur.phase_twelve == slpc_pkg::PHASE12_LAST) ? 4'd0
			: cur.phase_twelve + 4'd1;
		if (link_hit)   nxt.link_left   = cur.link_left   - 8'd1;
		if (report_hit) nxt.report_left = cur.report_left - 8'd1;
		if (net_hit)    nxt.net_left    = cur.net_left    - 8'd1;
		if (bridge_hit) nxt.bridge_left = cur.bridge_left - 8'd1;
		if (alert_hit)  nxt.alert_left  = cur.alert_left  - 8'd1;
		if (test_hit)   nxt.test_left   = cur.test_left   - 8'd1;
	end

endmodule

>>> rtl/status_led_pattern_controller_core.sv
// Status LED pattern controller, top level.
// A tick transaction passes through the input register, then the result register, before its
// LED levels show; event transactions give no result.
// Throughput: one transaction per cycle, limited only by the result register drain.
// Reset (arst_n low, asynchronous): phases, counters and test mask clear to zero,
// length registers return to 4, 2, 12 and 24. Depends on slpc_pkg, slpc_tick_logic.
module status_led_pattern_controller_core (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [3:0] test_select,
	input  logic       link_connected,
	input  logic       link_advertising,
	input  logic       link_requested,
	input  logic       link_ready,
	input  logic       net_scanning,
	input  logic       net_has_address,
	input  logic       net_associated,
	input  logic       net_requested,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       link_led,
	output logic       net_led,
	output logic       activity_led,
	output logic       alert_led,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// length registers
	logic [7:0] activity_len_q, report_len_q, alert_len_q, test_len_q;

	// input stage
	logic                 valid_s1;
	logic [2:0]           op_s1;
	logic [3:0]           sel_s1;
	slpc_pkg::status_t    status_s1;

	// controller state and result register
	slpc_pkg::ctl_state_t state_q;
	slpc_pkg::ctl_state_t tick_nxt;
	slpc_pkg::led_t       tick_leds;
	slpc_pkg::led_t       leds_q;
	logic                 out_valid_q;

	logic is_tick_s1;
	logic advance_s1;

	// Configuration is always taken; the user only writes while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activity_len_q <= slpc_pkg::ACTIVITY_LEN_RST;
			report_len_q   <= slpc_pkg::REPORT_LEN_RST;
			alert_len_q    <= slpc_pkg::ALERT_LEN_RST;
			test_len_q     <= slpc_pkg::TEST_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				slpc_pkg::REG_ACTIVITY_LEN: activity_len_q <= cfg_data;
				slpc_pkg::REG_REPORT_LEN:   report_len_q   <= cfg_data;
				slpc_pkg::REG_ALERT_LEN:    alert_len_q    <= cfg_data;
				slpc_pkg::REG_TEST_LEN:     test_len_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// A tick needs a free result slot; events and the unused code never stall.
	assign is_tick_s1 = (op_s1 == slpc_pkg::OP_TICK);
	assign advance_s1 = valid_s1 && (!is_tick_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	// Capture the transaction in the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= operation;
			sel_s1    <= test_select;
			status_s1 <= '{link_connected, link_advertising, link_requested, link_ready,
			               net_scanning, net_has_address, net_associated, net_requested};
		end
	end

	slpc_tick_logic u_tick (
		.cur    (state_q),
		.status (status_s1),
		.leds   (tick_leds),
		.nxt    (tick_nxt)
	);

	// Apply the transaction in stage 1 to the controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			case (op_s1)
				slpc_pkg::OP_TICK:     state_q             <= tick_nxt;
				slpc_pkg::OP_LINK_ACT: state_q.link_left   <= activity_len_q;
				slpc_pkg::OP_REPORT:   state_q.report_left <= report_len_q;
				slpc_pkg::OP_NET_ACT:  state_q.net_left    <= activity_len_q;
				slpc_pkg::OP_BRIDGE:   state_q.bridge_left <= activity_len_q;
				slpc_pkg::OP_ERROR:    state_q.alert_left  <= alert_len_q;
				slpc_pkg::OP_TEST: begin
					state_q.blink_mask <= sel_s1;
					state_q.test_left  <= test_len_q;
				end
				default: ;
			endcase
		end
	end

	// Result register: load on a tick, drop once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && is_tick_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && is_tick_s1) begin
			leds_q <= tick_leds;
		end
	end

	assign out_valid    = out_valid_q;
	assign link_led     = leds_q.link;
	assign net_led      = leds_q.net;
	assign activity_led = leds_q.activity;
	assign alert_led    = leds_q.alert;

endmodule

>>> test/testbench.sv
// Testbench for status_led_pattern_controller_core: directed table, then random transactions
// under several length settings, each LED result checked against a local predictor or a typed row.
// Depends on slpc_pkg and the controller RTL.
module testbench;

	// code 7 is not an operation; the block must drop it without a result
	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam int CYCLE_LIMIT       = 200000;
	localparam int DRAIN_CYCLES      = 6;
	localparam int ITEMS_PER_SETTING = 80;
	localparam int SETTING_COUNT     = 5;
	localparam int IDLE_PERCENT      = 13;

	// one row of the directed table; leds is used only where typed is set
	typedef struct packed {
		logic [2:0]        op;
		logic [3:0]        sel;
		slpc_pkg::status_t flags;
		logic              typed;
		slpc_pkg::led_t    leds;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        operation;
	logic [3:0]        test_select;
	slpc_pkg::status_t flags;
	logic              out_valid;
	logic              out_ready;
	logic              link_led;
	logic              net_led;
	logic              activity_led;
	logic              alert_led;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [7:0]        cfg_data;

	// predictor copy of the controller: phases, counters, mask and lengths
	slpc_pkg::ctl_state_t shadow;
	logic [7:0] activity_len;
	logic [7:0] report_len;
	logic [7:0] alert_len;
	logic [7:0] blink_test_len;

	slpc_pkg::led_t expected_leds [$];
	slpc_pkg::led_t seen_leds;
	slpc_pkg::led_t wanted_leds;
	int         fails = 0;
	int         cycle_count = 0;
	logic       quiet;
	string      led_names [4] = '{"alert_led", "activity_led", "net_led", "link_led"};

	// directed part: extremes of every field, every operation, the unused code,
	// retrigger, report override while connected, and an empty test mask
	stim_row_t directed_rows [0:20] = '{
		'{slpc_pkg::OP_TICK,     4'h0, 8'h00, 1'b1, 4'b0000}, // after reset: all dark
		'{slpc_pkg::OP_TICK,     4'h0, 8'hFF, 1'b1, 4'b1100}, // connected lit, scanning fast
		'{OP_UNUSED,             4'hF, 8'hFF, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h40, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h30, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h20, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h02, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h01, 1'b0, 4'b0000},
		'{slpc_pkg::OP_LINK_ACT, 4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_REPORT,   4'h0, 8'hFF, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h80, 1'b0, 4'b0000},
		'{slpc_pkg::OP_NET_ACT,  4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_BRIDGE,   4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_ERROR,    4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TEST,     4'hF, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'hFF, 1'b0, 4'b0000},
		'{slpc_pkg::OP_LINK_ACT, 4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TEST,     4'h0, 8'hFF, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h00, 1'b0, 4'b0000},
		'{slpc_pkg::OP_TICK,     4'h0, 8'h0C, 1'b0, 4'b0000}
	};

	status_led_pattern_controller_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.test_select      (test_select),
		.link_connected   (flags.link_connected),
		.link_advertising (flags.link_advertising),
		.link_requested   (flags.link_requested),
		.link_ready       (flags.link_ready),
		.net_scanning     (flags.net_scanning),
		.net_has_address  (flags.net_has_address),
		.net_associated   (flags.net_associated),
		.net_requested    (flags.net_requested),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.link_led         (link_led),
		.net_led          (net_led),
		.activity_led     (activity_led),
		.alert_led        (alert_led),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the predictor by one accepted transaction. Events only load counters and the mask;
	// a tick picks each LED by priority, applies the overrides in order, and
	// returns 1 with the levels in leds.
	function automatic bit predict_leds(input logic [2:0] op, input logic [3:0] sel,
			input slpc_pkg::status_t st, output slpc_pkg::led_t leds);
		logic fast;
		logic mid_blink;
		logic slow;
		logic heart;
		logic dbl;
		leds = '0;
		case (op)
			slpc_pkg::OP_LINK_ACT: begin
				shadow.link_left = activity_len;
				return 1'b0;
			end
			slpc_pkg::OP_REPORT: begin
				shadow.report_left = report_len;
				return 1'b0;
			end
			slpc_pkg::OP_NET_ACT: begin
				shadow.net_left = activity_len;
				return 1'b0;
			end
			slpc_pkg::OP_BRIDGE: begin
				shadow.bridge_left = activity_len;
				return 1'b0;
			end
			slpc_pkg::OP_ERROR: begin
				shadow.alert_left = alert_len;
				return 1'b0;
			end
			slpc_pkg::OP_TEST: begin
				shadow.blink_mask = sel;
				shadow.test_left = blink_test_len;
				return 1'b0;
			end
			slpc_pkg::OP_TICK: ;
			default: return 1'b0;
		endcase

		fast      = shadow.phase_eight[0];
		mid_blink = shadow.phase_eight[1];
		slow      = shadow.phase_eight[2];
		heart     = (shadow.phase_eight == 3'd0);
		dbl       = (shadow.phase_twelve == 4'd0)
			|| (shadow.phase_twelve == slpc_pkg::DOUBLE_SECOND);

		if (st.link_connected) leds.link = 1'b1;
		else if (st.link_advertising) leds.link = mid_blink;
		else if (st.link_requested && st.link_ready) leds.link = heart;
		else if (st.link_requested) leds.link = slow;

		if (st.net_scanning) leds.net = fast;
		else if (st.net_has_address) leds.net = 1'b1;
		else if (st.net_associated) leds.net = dbl;
		else if (st.net_requested) leds.net = slow;

		// each live counter overrides its LEDs and counts down once
		if (shadow.link_left != 8'd0) begin
			shadow.link_left = shadow.link_left - 8'd1;
			leds.link = 1'b1;
			leds.activity = 1'b1;
		end
		if (shadow.report_left != 8'd0) begin
			shadow.report_left = shadow.report_left - 8'd1;
			leds.link = !st.link_connected;
			leds.activity = 1'b1;
		end
		if (shadow.net_left != 8'd0) begin
			shadow.net_left = shadow.net_left - 8'd1;
			leds.net = 1'b1;
			leds.activity = 1'b1;
		end
		if (shadow.bridge_left != 8'd0) begin
			shadow.bridge_left = shadow.bridge_left - 8'd1;
			leds.activity = 1'b1;
		end
		if (shadow.alert_left != 8'd0) begin
			shadow.alert_left = shadow.alert_left - 8'd1;
			leds.alert = fast;
		end
		if (shadow.test_left != 8'd0) begin
			shadow.test_left = shadow.test_left - 8'd1;
			if (shadow.blink_mask[0]) leds.link = fast;
			if (shadow.blink_mask[1]) leds.net = fast;
			if (shadow.blink_mask[2]) leds.activity = fast;
			if (shadow.blink_mask[3]) leds.alert = fast;
		end

		shadow.phase_eight = shadow.phase_eight + 3'd1;
		shadow.phase_twelve = (shadow.phase_twelve == slpc_pkg::PHASE12_LAST) ? 4'd0
			: shadow.phase_twelve + 4'd1;
		return 1'b1;
	endfunction

	// Offer one transaction on the input channel, hold it until accepted, then
	// queue any expected LEDs. A typed row queues its own levels instead.
	task automatic send_item(input logic [2:0] op, input logic [3:0] sel,
			input slpc_pkg::status_t st, input logic typed, input slpc_pkg::led_t typed_leds);
		slpc_pkg::led_t predicted;
		bit             has_result;
		while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		test_select <= sel;
		flags <= st;
		do @(posedge clk); while (!in_ready);
		has_result = predict_leds(op, sel, st, predicted);
		if (has_result) expected_leds.push_back(typed ? typed_leds : predicted);
	endtask

	// Drop valid, wait for every expected result, then let an event transaction
	// still in the pipeline finish before touching the registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_leds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four length registers back to back; valid stays high between writes.
	task automatic write_lengths(input logic [7:0] act, input logic [7:0] rep,
			input logic [7:0] alrt, input logic [7:0] tst);
		logic [7:0] vals [4];
		logic [1:0] idxs [4];
		vals = '{act, rep, alrt, tst};
		idxs = '{slpc_pkg::REG_ACTIVITY_LEN, slpc_pkg::REG_REPORT_LEN,
			slpc_pkg::REG_ALERT_LEN, slpc_pkg::REG_TEST_LEN};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idxs[i])
				slpc_pkg::REG_ACTIVITY_LEN: activity_len = vals[i];
				slpc_pkg::REG_REPORT_LEN:   report_len = vals[i];
				slpc_pkg::REG_ALERT_LEN:    alert_len = vals[i];
				slpc_pkg::REG_TEST_LEN:     blink_test_len = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Result side: stall at random, and check each accepted result against the
	// oldest expectation, one LED at a time.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen_leds = {link_led, net_led, activity_led, alert_led};
				if (expected_leds.size() == 0) begin
					$display("%0t: LED result %b arrived with none expected", $time, seen_leds);
					fails++;
				end else begin
					wanted_leds = expected_leds.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (seen_leds[i] !== wanted_leds[i]) begin
							$display("%0t: %s mismatch: expected %b, actual %b", $time,
								led_names[i], wanted_leds[i], seen_leds[i]);
							fails++;
						end
					end
				end
			end
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [2:0] op;
		int         roll;
		int         sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = slpc_pkg::OP_TICK;
		test_select = 4'h0;
		flags = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = slpc_pkg::REG_ACTIVITY_LEN;
		cfg_data = 8'd0;
		quiet = 1'b0;
		shadow = '0;
		activity_len = slpc_pkg::ACTIVITY_LEN_RST;
		report_len = slpc_pkg::REPORT_LEN_RST;
		alert_len = slpc_pkg::ALERT_LEN_RST;
		blink_test_len = slpc_pkg::TEST_LEN_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with the reset lengths
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].flags,
				directed_rows[i].typed, directed_rows[i].leds);

		// Random transactions under each length setting: all zero, all full scale,
		// all one, then two random settings kept short so counters expire often.
		// The fourth setting runs with no idling on either side.
		for (int s = 0; s < SETTING_COUNT; s++) begin
			settle();
			case (s)
				0: write_lengths(8'd0, 8'd0, 8'd0, 8'd0);
				1: write_lengths(8'd255, 8'd255, 8'd255, 8'd255);
				2: write_lengths(8'd1, 8'd1, 8'd1, 8'd1);
				default: write_lengths(8'($urandom_range(12)), 8'($urandom_range(12)),
					8'($urandom_range(30)), 8'($urandom_range(30)));
			endcase
			quiet <= (s == 3);
			sent = 0;
			while (sent < ITEMS_PER_SETTING) begin
				roll = $urandom_range(99);
				if (roll < 55) op = slpc_pkg::OP_TICK;
				else if (roll < 97)
					op = 3'($urandom_range(slpc_pkg::OP_TEST, slpc_pkg::OP_LINK_ACT));
				else op = OP_UNUSED;
				send_item(op, 4'($urandom_range(15)), 8'($urandom_range(255)), 1'b0, '0);
				if (op != OP_UNUSED) sent++;
			end
		end

		settle();
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
